[sv/unique_message_generation_table_macros.svh]
// Assertion macros for the unique message generation table.
// Each expects signals named clk and rst in the scope of use.
`ifndef UNIQUE_MESSAGE_GENERATION_TABLE_MACROS_SVH
`define UNIQUE_MESSAGE_GENERATION_TABLE_MACROS_SVH

// Same-cycle implication.
`define UMGT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UMGT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/umgt_pkg.sv]
`default_nettype none
package umgt_pkg;

  localparam int HANDLERS_DEF = 16;
  localparam int SLOTS_DEF    = 8;

  localparam int KIND_W    = 3;
  localparam int HANDLER_W = 4;
  localparam int ID_W      = 16;
  localparam int AGE_W     = 32;
  // Handler index widened so that any HANDLERS up to 256 compares cleanly
  localparam int HEXT_W    = 9;

  localparam logic [AGE_W-1:0] GEN_INIT = AGE_W'(1);
  localparam logic [AGE_W-1:0] GEN_MAX  = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_POST    = 3'd0,
    KIND_REMOVE  = 3'd1,
    KIND_CHECK   = 3'd2,
    KIND_CONSUME = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [HANDLER_W-1:0] handler;
    logic [ID_W-1:0]      msg_id;
    logic [AGE_W-1:0]     msg_age;
  } req_t;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic             valid_res;
    logic             full_res;
  } rsp_t;

  // Row update request from the slot logic
  typedef struct packed {
    logic wr;
    logic clr;
  } upd_t;

endpackage
`default_nettype wire

[sv/umgt_row_mem.sv]
`default_nettype none
module umgt_row_mem
  import umgt_pkg::*;
#(
  parameter int DEPTH = HANDLERS_DEF,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[sv/umgt_slot_logic.sv]
`default_nettype none
module umgt_slot_logic
  import umgt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int SW    = 3
) (
  input  wire req_t                         req,
  input  wire logic                         in_range,
  input  wire logic [SLOTS-1:0][ID_W-1:0]   ids_in,
  input  wire logic [SLOTS-1:0][AGE_W-1:0]  ages_in,
  input  wire logic [AGE_W-1:0]             gen_in,
  output logic      [SLOTS-1:0][ID_W-1:0]   ids_out,
  output logic      [SLOTS-1:0][AGE_W-1:0]  ages_out,
  output logic      [AGE_W-1:0]             gen_out,
  output upd_t                              upd,
  output rsp_t                              res
);

  logic [SLOTS-1:0] empty;
  logic [SLOTS-1:0] match;
  logic             found;
  logic [SW-1:0]    fp;
  logic             hit;
  logic             free;
  logic             id_nz;

  // Compare every slot against the id in parallel
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      empty[s] = (ids_in[s] == '0);
      match[s] = (ids_in[s] == req.msg_id);
    end
  end

  // Lookup stops at the first empty slot or the first match
  always_comb begin
    found = 1'b0;
    fp    = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (empty[s] || match[s]) begin
        found = 1'b1;
        fp    = SW'(s);
      end
    end
  end

  assign id_nz = (req.msg_id != '0);
  assign hit   = found && !empty[fp];
  assign free  = found && empty[fp];

  // Update of the row and the result
  always_comb begin
    ids_out  = ids_in;
    ages_out = ages_in;
    gen_out  = gen_in;
    upd      = '0;
    res      = '0;
    if (in_range) begin
      unique case (req.kind)
        KIND_POST, KIND_REMOVE: begin
          if (id_nz) begin
            if (hit || free) begin
              upd.wr      = 1'b1;
              ids_out[fp] = req.msg_id;
              if (req.kind == KIND_POST) begin
                ages_out[fp] = gen_in;
                res.age      = gen_in;
                if (gen_in != GEN_MAX) begin
                  gen_out = gen_in + AGE_W'(1);
                end
              end else begin
                ages_out[fp] = '0;
              end
            end else begin
              res.full_res = 1'b1;
            end
          end
        end
        KIND_CHECK, KIND_CONSUME: begin
          if (id_nz && hit && (req.msg_age >= ages_in[fp])) begin
            res.valid_res = 1'b1;
            if (req.kind == KIND_CONSUME) begin
              upd.wr       = 1'b1;
              ages_out[fp] = '0;
            end
          end
        end
        KIND_CLEAR: begin
          upd.clr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/unique_message_generation_table.sv]
// Unique message generation table.
// Request channel (req_valid / req_stall / req) carries one operation:
// post, remove, check, check and consume, or clear of a handler row.
// Response channel (rsp_valid / rsp_stall / rsp) returns exactly one
// transaction per request: the stored generation, the check verdict and
// the full-row flag.
// Each handler row (ids, generations and the next-generation counter) is
// one word of a single-port-read, single-port-write memory. A request is
// taken in IDLE while its row is read, and is resolved and written back
// in EXEC once the response register is free. req_stall is high in EXEC,
// so no new request is taken before the write-back of the last one.
// The response is registered at that write-back. A waiting response does
// not block the next request; the write-back of that request holds until
// the response register frees.
// Reset (rst, synchronous) clears the per-row valid flags; a row
// not valid reads as empty with its counter at 1, so no clearing pass is
// needed and requests are taken right after reset. A clear operation just
// drops the row's valid flag.
`default_nettype none
module unique_message_generation_table
  import umgt_pkg::*;
#(
  parameter int HANDLERS = HANDLERS_DEF,
  parameter int SLOTS    = SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

`include "unique_message_generation_table_macros.svh"

  localparam int AW = (HANDLERS > 1) ? $clog2(HANDLERS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = SLOTS * (ID_W + AGE_W) + AGE_W;

  state_t state_q, state_next;

  logic                          req_accept;
  logic                          out_free;
  logic                          commit;
  logic [HEXT_W-1:0]             h_ext;
  logic                          h_in_range;
  logic [AW-1:0]                 h_addr;

  req_t                          req_q;
  logic [AW-1:0]                 addr_q;
  logic                          in_range_q;
  logic                          row_vld_q;
  logic [HANDLERS-1:0]           row_vld;

  logic [RW-1:0]                 rd_data;
  logic [RW-1:0]                 wr_data;
  logic [SLOTS-1:0][ID_W-1:0]    rd_ids, cur_ids, new_ids;
  logic [SLOTS-1:0][AGE_W-1:0]   rd_ages, cur_ages, new_ages;
  logic [AGE_W-1:0]              rd_gen, cur_gen, new_gen;
  upd_t                          upd;
  rsp_t                          res;

  // Handshake
  assign req_stall  = (state_q != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign commit     = (state_q == ST_EXEC) && out_free;

  // Handler decode
  assign h_ext      = {{(HEXT_W - HANDLER_W){1'b0}}, req.handler};
  assign h_in_range = (h_ext < HEXT_W'(HANDLERS));
  assign h_addr     = h_ext[AW-1:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_next;
    end
  end

  always_comb begin
    state_next = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Request capture, held while the row is resolved
  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_q      <= req;
      addr_q     <= h_addr;
      in_range_q <= h_in_range;
      row_vld_q  <= h_in_range && row_vld[h_addr];
    end
  end

  // Row valid flags: set on write-back, dropped by clear
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (commit) begin
      if (upd.clr) begin
        row_vld[addr_q] <= 1'b0;
      end else if (upd.wr) begin
        row_vld[addr_q] <= 1'b1;
      end
    end
  end

  umgt_row_mem #(
    .DEPTH (HANDLERS),
    .WIDTH (RW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (req_accept && h_in_range),
    .rd_addr (h_addr),
    .rd_data (rd_data),
    .wr_en   (commit && upd.wr),
    .wr_addr (addr_q),
    .wr_data (wr_data)
  );

  // A row never written reads as empty with the counter at its start
  assign {rd_gen, rd_ages, rd_ids} = rd_data;
  assign cur_ids  = row_vld_q ? rd_ids  : '0;
  assign cur_ages = row_vld_q ? rd_ages : '0;
  assign cur_gen  = row_vld_q ? rd_gen  : GEN_INIT;
  assign wr_data  = {new_gen, new_ages, new_ids};

  umgt_slot_logic #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_slots (
    .req      (req_q),
    .in_range (in_range_q),
    .ids_in   (cur_ids),
    .ages_in  (cur_ages),
    .gen_in   (cur_gen),
    .ids_out  (new_ids),
    .ages_out (new_ages),
    .gen_out  (new_gen),
    .upd      (upd),
    .res      (res)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp <= res;
    end
  end

  // Checks
  `UMGT_ASSERT_NXT(a_accept_exec, req_accept, state_q == ST_EXEC, "accepted request not in exec")
  `UMGT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
  `UMGT_ASSERT_NXT(a_commit_rsp, commit, rsp_valid, "commit did not present a response")
  `UMGT_ASSERT_IMP(a_full_no_age, rsp_valid && rsp.full_res, rsp.age == '0 && !rsp.valid_res, "full response with age or verdict")

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import umgt_pkg::*;

  // Kinds outside the decoded range; the block must answer them with zeros
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
  localparam int MAX_REPORTS = 10;

  // Mirror of the generation table plus the queue of responses still owed
  class generation_scoreboard;
    logic [ID_W-1:0]  row_id[HANDLERS_DEF][SLOTS_DEF];
    logic [AGE_W-1:0] row_gen[HANDLERS_DEF][SLOTS_DEF];
    logic [AGE_W-1:0] next_gen[HANDLERS_DEF];
    rsp_t owed_responses[$];
    int failures;
    int checked;
    int current_seen;
    int full_seen;

    function new();
      for (int h = 0; h < HANDLERS_DEF; h++) begin
        wipe_row(h);
      end
      failures = 0;
      checked = 0;
      current_seen = 0;
      full_seen = 0;
    endfunction

    function void wipe_row(int h);
      for (int s = 0; s < SLOTS_DEF; s++) begin
        row_id[h][s] = '0;
        row_gen[h][s] = '0;
      end
      next_gen[h] = GEN_INIT;
    endfunction

    // Applies one request to the mirror and returns the response it owes
    function rsp_t resolve_request(req_t r);
      rsp_t o;
      int h;
      int hit;
      int free_s;
      int idx;
      o = '0;
      h = int'(r.handler);
      if (h >= HANDLERS_DEF || r.kind > KIND_CLEAR) return o;
      if (r.kind == KIND_CLEAR) begin
        wipe_row(h);
        return o;
      end
      if (r.msg_id == '0) return o;

      // rows fill in order, so the search stops at the first empty slot
      hit = -1;
      free_s = SLOTS_DEF;
      for (int s = 0; s < SLOTS_DEF; s++) begin
        if (row_id[h][s] == '0) begin
          free_s = s;
          break;
        end
        if (row_id[h][s] == r.msg_id) begin
          hit = s;
          break;
        end
      end

      if (r.kind == KIND_POST || r.kind == KIND_REMOVE) begin
        idx = -1;
        if (hit >= 0) begin
          idx = hit;
        end else if (free_s < SLOTS_DEF) begin
          idx = free_s;
          row_id[h][idx] = r.msg_id;
        end else begin
          o.full_res = 1'b1;
        end
        if (idx >= 0) begin
          if (r.kind == KIND_POST) begin
            o.age = next_gen[h];
            if (next_gen[h] != GEN_MAX) next_gen[h] = next_gen[h] + 1;
          end
          row_gen[h][idx] = o.age;
        end
      end else if (hit >= 0 && r.msg_age >= row_gen[h][hit]) begin
        // check passes; a consuming check also retires the generation
        o.valid_res = 1'b1;
        if (r.kind == KIND_CONSUME) row_gen[h][hit] = '0;
      end
      return o;
    endfunction

    function void note_request(req_t r);
      owed_responses.push_back(resolve_request(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      checked++;
      if (owed_responses.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected response: age=%h valid=%b full=%b",
                   got.age, got.valid_res, got.full_res);
        return;
      end
      want = owed_responses.pop_front();
      if (want.valid_res) current_seen++;
      if (want.full_res) full_seen++;
      if (got.age !== want.age || got.valid_res !== want.valid_res ||
          got.full_res !== want.full_res) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("mismatch: expected age=%h valid=%b full=%b, got age=%h valid=%b full=%b",
                   want.age, want.valid_res, want.full_res,
                   got.age, got.valid_res, got.full_res);
      end
    endfunction

    function int outstanding();
      return owed_responses.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic req_idle_on = 1'b1;
  logic rsp_idle_on = 1'b1;
  int rsp_hold_left = 0;
  int sent = 0;

  generation_scoreboard sb = new();

  unique_message_generation_table uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor both channels at the edge where transactions complete
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  // Response side: a long hold when asked, otherwise random stalls unless idling is off
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (rsp_hold_left > 0) begin
      rsp_stall <= 1'b1;
      rsp_hold_left <= rsp_hold_left - 1;
    end else begin
      rsp_stall <= rsp_idle_on && ($urandom_range(0, 99) < 15);
    end
  end

  // Offers one transaction and returns at the edge it is taken
  task automatic send_request(input req_t r);
    if (req_idle_on && $urandom_range(0, 99) < 15) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  function automatic req_t make_req(logic [KIND_W-1:0] k, logic [HANDLER_W-1:0] h,
                                    logic [ID_W-1:0] id, logic [AGE_W-1:0] a);
    req_t r;
    r.kind = k;
    r.handler = h;
    r.msg_id = id;
    r.msg_age = a;
    return r;
  endfunction

  // Mostly well-formed traffic on a few hot rows with a small id pool,
  // so rows fill up, ids get superseded and checks land near the boundary
  task automatic run_random(input int count);
    int p;
    logic [KIND_W-1:0] k;
    logic [HANDLER_W-1:0] h;
    logic [ID_W-1:0] id;
    logic [AGE_W-1:0] a;
    logic [ID_W-1:0] pool[12];
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        foreach (pool[j]) pool[j] = ID_W'($urandom_range(1, 65535));
      end
      p = $urandom_range(0, 99);
      h = ($urandom_range(0, 99) < 70) ? HANDLER_W'($urandom_range(0, 3))
                                       : HANDLER_W'($urandom_range(0, 15));
      id = pool[$urandom_range(0, 11)];
      if (p < 35) k = KIND_POST;
      else if (p < 45) k = KIND_REMOVE;
      else if (p < 65) k = KIND_CHECK;
      else if (p < 85) k = KIND_CONSUME;
      else if (p < 89) k = KIND_CLEAR;
      else if (p < 94) begin
        // noise: unused kind, or a decoded kind with the reserved zero id
        if ($urandom_range(0, 1) == 0) begin
          k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end else begin
          k = KIND_W'($urandom_range(KIND_POST, KIND_CONSUME));
          id = '0;
        end
      end else begin
        k = ($urandom_range(0, 1) == 0) ? KIND_POST : KIND_CHECK;
        id = ID_W'($urandom_range(1, 65535));
      end
      case ($urandom_range(0, 4))
        0: a = $urandom;
        1: a = sb.next_gen[h] - 1;
        2: a = sb.next_gen[h] - 2;
        3: a = '0;
        default: a = sb.next_gen[h] - $urandom_range(1, 6);
      endcase
      send_request(make_req(k, h, id, a));
    end
  endtask

  task automatic drain_responses();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: supersede, stale and current checks, consume, remove
    send_request(make_req(KIND_POST, 4'd0, 16'h0001, '0));
    send_request(make_req(KIND_POST, 4'd0, 16'hFFFF, '1));
    send_request(make_req(KIND_POST, 4'd0, 16'h0001, '0));
    send_request(make_req(KIND_CHECK, 4'd0, 16'h0001, 32'd2));
    send_request(make_req(KIND_CHECK, 4'd0, 16'h0001, 32'd3));
    send_request(make_req(KIND_CHECK, 4'd0, 16'hFFFF, '1));
    send_request(make_req(KIND_CONSUME, 4'd0, 16'h0001, 32'd3));
    send_request(make_req(KIND_CHECK, 4'd0, 16'h0001, '0));
    send_request(make_req(KIND_CHECK, 4'd0, 16'h1234, '1));
    send_request(make_req(KIND_REMOVE, 4'd0, 16'hFFFF, '0));
    send_request(make_req(KIND_REMOVE, 4'd0, 16'h00AA, '0));

    // fill the last row, then hit it with absent and present ids
    for (int s = 0; s < SLOTS_DEF; s++) begin
      send_request(make_req(KIND_POST, 4'd15, ID_W'(16'h8001 + s), '0));
    end
    send_request(make_req(KIND_POST, 4'd15, 16'h8009, '0));
    send_request(make_req(KIND_REMOVE, 4'd15, 16'h800A, '0));
    send_request(make_req(KIND_POST, 4'd15, 16'h8003, '0));

    // ignored requests, then a row clear restarting the counter
    send_request(make_req(KIND_POST, 4'd15, 16'h0000, '1));
    send_request(make_req(KIND_UNUSED_LO, 4'd15, 16'h8003, '1));
    send_request(make_req(KIND_UNUSED_HI, 4'd0, 16'hFFFF, '0));
    send_request(make_req(KIND_CLEAR, 4'd15, 16'h8003, '0));
    send_request(make_req(KIND_POST, 4'd15, 16'h8009, '0));

    run_random(750);

    // back pressure: receiver holds off while the sender keeps offering
    rsp_hold_left <= 200;
    req_idle_on <= 1'b0;
    run_random(40);
    req_valid <= 1'b0;
    drain_responses();

    // stretch with no idling on either side
    rsp_idle_on <= 1'b0;
    run_random(550);

    req_idle_on <= 1'b1;
    rsp_idle_on <= 1'b1;
    run_random(600);

    req_valid <= 1'b0;
    drain_responses();
    repeat (10) @(posedge clk);

    $display("%0d requests sent, %0d responses checked", sent, sb.checked);
    $display("%0d checks found the message current, %0d posts/removes hit a full row",
             sb.current_seen, sb.full_seen);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d responses missing", sb.failures, sb.outstanding());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d responses outstanding", sb.outstanding());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/umgt_pkg.sv
sv/umgt_row_mem.sv
sv/umgt_slot_logic.sv
sv/unique_message_generation_table.sv
tb/testbench.sv
